// ----- design/masked_byte_pattern_scan_defines.svh -----
// Assertion macros for the masked byte pattern scan checker.
// No dependencies; include by bare file name.
`ifndef MASKED_BYTE_PATTERN_SCAN_DEFINES_SVH
`define MASKED_BYTE_PATTERN_SCAN_DEFINES_SVH

// same-cycle implication, disabled in reset
`define MBPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("masked_byte_pattern_scan: assertion failed");

// next-cycle implication, disabled in reset
`define MBPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("masked_byte_pattern_scan: assertion failed");

// next-cycle implication, active through reset
`define MBPS_ASSERT_RST(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("masked_byte_pattern_scan: reset assertion failed");

`endif

// ----- design/mbps_pkg.sv -----
// Shared constants and types for the masked byte pattern scan.
// No dependencies.
package mbps_pkg;

  localparam int PATTERN_MAX_DEF = 16;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 64;
  localparam int ADDR_W          = 64;
  localparam int COUNT_W         = 32;
  localparam int LEN_W           = 5;
  localparam int MASK_W          = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LO  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_HI  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WILD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE    = 3'd4;

  typedef struct packed {
    logic [63:0]        pat_lo;
    logic [63:0]        pat_hi;
    logic [MASK_W-1:0]  wild;
    logic [LEN_W-1:0]   length;
    logic [ADDR_W-1:0]  base;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] mem_byte;
    logic       last_byte;
  } word_t;

endpackage

// ----- design/masked_byte_pattern_scan.sv -----
// Top level of the masked byte pattern scan: config registers, input stage, match core.
// Depends on mbps_pkg, mbps_cfg_regs, mbps_in_stage, mbps_match_core.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+--------------------------------
//   in       | in_valid / in_stall   | in_mem_byte, in_last_byte
//   out      | out_valid / out_stall | out_found, out_match_address
//   cfg      | cfg_wr_en             | cfg_index, cfg_wdata
//
// One word per cycle while in_stall is low; a result is registered behind the input stage.
// The combinational masked compare of the byte window against the pattern sets the rate.
// Synchronous reset clears the window, the counter, the match flag and both valid bits.
// A stalled result holds in the output register; the input stage keeps taking words
// until it holds one the core cannot take.
module masked_byte_pattern_scan #(
  parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_mem_byte,
  input  logic                            in_last_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_found,
  output logic [mbps_pkg::ADDR_W-1:0]     out_match_address,
  input  logic                            cfg_wr_en,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import mbps_pkg::*;

  cfg_t  cfg;
  word_t word;
  logic  core_ready;

  mbps_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mbps_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mem_byte  (in_mem_byte),
    .in_last_byte (in_last_byte),
    .core_ready   (core_ready),
    .word         (word)
  );

  mbps_match_core #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_core (
    .clk               (clk),
    .rst_n             (rst_n),
    .word              (word),
    .cfg               (cfg),
    .core_ready        (core_ready),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_found         (out_found),
    .out_match_address (out_match_address)
  );

endmodule

// ----- design/mbps_cfg_regs.sv -----
// Configuration register file for the masked byte pattern scan.
// Depends on mbps_pkg.
module mbps_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output mbps_pkg::cfg_t                  cfg
);
  import mbps_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_PAT_LO: cfg_nxt.pat_lo = cfg_wdata;
        CFG_PAT_HI: cfg_nxt.pat_hi = cfg_wdata;
        CFG_WILD:   cfg_nxt.wild   = cfg_wdata[MASK_W-1:0];
        CFG_LENGTH: cfg_nxt.length = cfg_wdata[LEN_W-1:0];
        CFG_BASE:   cfg_nxt.base   = cfg_wdata[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pat_lo <= '0;
      cfg_r.pat_hi <= '0;
      cfg_r.wild   <= '0;
      cfg_r.length <= LEN_W'(1);
      cfg_r.base   <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- design/mbps_in_stage.sv -----
// Input register stage: captures one word and holds it until the core takes it.
// Depends on mbps_pkg.
module mbps_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_mem_byte,
  input  logic            in_last_byte,
  input  logic            core_ready,
  output mbps_pkg::word_t word
);
  import mbps_pkg::*;

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       last_r, last_nxt;
  logic       take;

  assign in_stall = valid_r && !core_ready;
  assign take     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    if (take) begin
      valid_nxt = 1'b1;
      byte_nxt  = in_mem_byte;
      last_nxt  = in_last_byte;
    end else if (core_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

  assign word.valid     = valid_r;
  assign word.mem_byte  = byte_r;
  assign word.last_byte = last_r;

endmodule

// ----- design/mbps_match_core.sv -----
// Byte window, byte counter, parallel masked compare and result register.
// Depends on mbps_pkg.
module mbps_match_core #(
  parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mbps_pkg::word_t              word,
  input  mbps_pkg::cfg_t               cfg,
  output logic                         core_ready,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_found,
  output logic [mbps_pkg::ADDR_W-1:0]  out_match_address
);
  import mbps_pkg::*;

  localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam logic [LEN_W-1:0] LEN_TOP = LEN_W'(PATTERN_MAX);

  logic [7:0]         win_r [PATTERN_MAX];
  logic [7:0]         win_nxt [PATTERN_MAX];
  logic [7:0]         win_new [PATTERN_MAX];
  logic [COUNT_W-1:0] seen_r, seen_nxt, seen_inc, offset;
  logic               done_r, done_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_found_r, out_found_nxt;
  logic [ADDR_W-1:0]  out_addr_r, out_addr_nxt;
  logic [LEN_W-1:0]   len_used;
  logic [127:0]       pat;
  logic               bytes_ok, hit, advance, fire;

  assign core_ready = !out_valid_r || !out_stall;
  assign advance    = word.valid && core_ready;
  assign pat        = {cfg.pat_hi, cfg.pat_lo};

  always_comb begin
    if (cfg.length == '0) begin
      len_used = LEN_W'(1);
    end else if (cfg.length > LEN_TOP) begin
      len_used = LEN_TOP;
    end else begin
      len_used = cfg.length;
    end
  end

  always_comb begin
    win_new[0] = word.mem_byte;
    for (int k = 1; k < PATTERN_MAX; k++) begin
      win_new[k] = win_r[k-1];
    end
  end

  assign seen_inc = (seen_r == '1) ? seen_r : seen_r + COUNT_W'(1);
  assign offset   = seen_inc - COUNT_W'(len_used);

  // pattern byte j lines up with the byte that arrived len-1-j words ago
  always_comb begin
    logic [LEN_W-1:0] pos;
    bytes_ok = 1'b1;
    for (int j = 0; j < PATTERN_MAX; j++) begin
      pos = len_used - LEN_W'(j) - LEN_W'(1);
      if ((LEN_W'(j) < len_used) && !cfg.wild[j] &&
          (win_new[pos[IDX_W-1:0]] != pat[j*8 +: 8])) begin
        bytes_ok = 1'b0;
      end
    end
  end

  assign hit = bytes_ok && (seen_inc >= COUNT_W'(len_used));

  always_comb begin
    win_nxt       = win_r;
    seen_nxt      = seen_r;
    done_nxt      = done_r;
    fire          = 1'b0;
    out_found_nxt = out_found_r;
    out_addr_nxt  = out_addr_r;
    if (advance) begin
      if (!done_r) begin
        win_nxt  = win_new;
        seen_nxt = seen_inc;
        if (hit) begin
          done_nxt      = 1'b1;
          fire          = 1'b1;
          out_found_nxt = 1'b1;
          out_addr_nxt  = cfg.base + ADDR_W'(offset);
        end else if (word.last_byte) begin
          fire          = 1'b1;
          out_found_nxt = 1'b0;
          out_addr_nxt  = '0;
        end
      end
      if (word.last_byte) begin
        for (int k = 0; k < PATTERN_MAX; k++) begin
          win_nxt[k] = '0;
        end
        seen_nxt = '0;
        done_nxt = 1'b0;
      end
    end
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
        win_r[k] <= '0;
      end
      seen_r      <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      win_r       <= win_nxt;
      seen_r      <= seen_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_found_r <= out_found_nxt;
    out_addr_r  <= out_addr_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_match_address = out_addr_r;

endmodule

// ----- design/mbps_checker.sv -----
// Port-level checker for the masked byte pattern scan, bound to the top level.
// Depends on mbps_pkg and masked_byte_pattern_scan_defines.svh.
`include "masked_byte_pattern_scan_defines.svh"

module mbps_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        out_found,
  input logic [mbps_pkg::ADDR_W-1:0] out_match_address
);

  `MBPS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_found) && $stable(out_match_address))
  `MBPS_ASSERT_NOW(a_miss_zero_addr, clk, rst_n, out_valid && !out_found, out_match_address == '0)
  `MBPS_ASSERT_NOW(a_no_stall_when_out_empty, clk, rst_n, !out_valid, !in_stall)
  `MBPS_ASSERT_RST(a_reset_clears_out, clk, !rst_n, !out_valid && !in_stall)

endmodule

bind masked_byte_pattern_scan mbps_checker u_mbps_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_found         (out_found),
  .out_match_address (out_match_address)
);
